// ===== sv/meab_pkg.sv =====
`timescale 1ns / 1ps

package meab_pkg;

    localparam int MAX_VERTICES = 4096;
    localparam int MAX_EDGES    = 16384;
    localparam int MAX_DEGREE   = 16;
    localparam int MAX_FACES    = 8192;

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int EW  = $clog2(MAX_EDGES);
    localparam int ETW = EW + 1;
    localparam int DW  = $clog2(MAX_DEGREE);
    localparam int DGW = DW + 1;
    localparam int FIW = $clog2(MAX_FACES);
    localparam int FTW = FIW + 1;
    localparam int LAW = VW + DW;
    localparam int NCALL = 6;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_NONMAN = 2'd1;
    localparam logic [1:0] STATUS_OVF    = 2'd2;

    // list insertions in order: corner slot and edge slot (0 ab, 1 bc, 2 ca)
    localparam logic [1:0] CALL_V [NCALL] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
    localparam logic [1:0] CALL_K [NCALL] = '{2'd2, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};

    typedef struct packed {
        logic [11:0] vertex_a;
        logic [11:0] vertex_b;
        logic [11:0] vertex_c;
    } face_t;

    typedef struct packed {
        logic [12:0] face_index;
        logic [13:0] edge_ab;
        logic [13:0] edge_bc;
        logic [13:0] edge_ca;
        logic        new_ab;
        logic        new_bc;
        logic        new_ca;
        logic [1:0]  status;
    } adj_t;

    typedef struct packed {
        face_t corners;
        logic  eq_ab;
        logic  eq_bc;
        logic  eq_ca;
    } job_t;

    typedef struct packed {
        logic clearing;
    } back_stat_t;

    typedef enum logic [3:0] {
        CLEAR,
        IDLE,
        DEG_A,
        DEG_B,
        DEG_C,
        DEG_W,
        SCAN_A,
        SCAN_B,
        ALLOC,
        APPEND,
        EDGE_RD,
        EDGE_WR,
        DONE
    } state_t;

    // true when two corner slots hold the same vertex
    function automatic logic vsame(input logic [1:0] s, input logic [1:0] t,
                                   input logic eab, input logic ebc, input logic eca);
        logic r;
        begin
            if (s == t)
            begin
                r = 1'b1;
            end
            else if ((s == 2'd0 && t == 2'd1) || (s == 2'd1 && t == 2'd0))
            begin
                r = eab;
            end
            else if ((s == 2'd1 && t == 2'd2) || (s == 2'd2 && t == 2'd1))
            begin
                r = ebc;
            end
            else
            begin
                r = eca;
            end
            return r;
        end
    endfunction

endpackage

// ===== sv/mesh_edge_adjacency_builder.sv =====
`timescale 1ns / 1ps

// Builds undirected edge adjacency for a triangle mesh, one face per request, results in
// request order. After reset the per-vertex degree counts are cleared by a pass over every
// vertex during which face_stall stays high. Each face then scans the edge lists of corners
// A and B; a scan may stop early on a hit, and each list holds at most 16 entries.
// The back sequencer walks each list one entry per cycle through the list and endpoint
// memories, then writes the list entries with the degree counts, then the edge records one
// at a time, and starts the next face only once the previous result has been taken. Faces
// beyond the face limit return at once with overflow status, as do faces that would overflow
// the edge count or a vertex list. A two-entry queue in front takes new faces while the back
// end works.

module mesh_edge_adjacency_builder
    import meab_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  face_valid,
    output logic  face_stall,
    input  face_t face,
    output logic  adj_valid,
    input  logic  adj_stall,
    output adj_t  adj
);

    back_stat_t stat;
    logic       q_valid;
    job_t       q_job;
    logic       q_pop;

    meab_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .face_valid (face_valid),
        .face_stall (face_stall),
        .face       (face),
        .stat       (stat),
        .q_valid    (q_valid),
        .q_job      (q_job),
        .q_pop      (q_pop)
    );

    meab_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_job     (q_job),
        .q_pop     (q_pop),
        .stat      (stat),
        .adj_valid (adj_valid),
        .adj_stall (adj_stall),
        .adj       (adj)
    );

endmodule

// ===== sv/meab_front.sv =====
`timescale 1ns / 1ps

module meab_front
    import meab_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       face_valid,
    output logic       face_stall,
    input  face_t      face,
    input  back_stat_t stat,
    output logic       q_valid,
    output job_t       q_job,
    input  logic       q_pop
);

    job_t       buf_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic       push;
    job_t       job_new;

    assign face_stall = (cnt_reg == 2'd2) || stat.clearing;
    assign push       = face_valid && !face_stall;
    assign q_valid    = (cnt_reg != 2'd0);
    assign q_job      = buf_reg[rp_reg];

    // repeated corners
    always_comb
    begin
        job_new.corners = face;
        job_new.eq_ab   = (face.vertex_a == face.vertex_b);
        job_new.eq_bc   = (face.vertex_b == face.vertex_c);
        job_new.eq_ca   = (face.vertex_c == face.vertex_a);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= !wp_reg;
            end
            if (q_pop)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wp_reg] <= job_new;
        end
    end

endmodule

// ===== sv/meab_back.sv =====
`timescale 1ns / 1ps

module meab_back
    import meab_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  job_t       q_job,
    output logic       q_pop,
    output back_stat_t stat,
    output logic       adj_valid,
    input  logic       adj_stall,
    output adj_t       adj
);

    state_t state_reg, state_next;

    job_t            job_reg;
    logic [FTW-1:0]  face_total_reg;
    logic [ETW-1:0]  edge_total_reg;
    logic [ETW-1:0]  next_total_reg;
    logic [VW-1:0]   clr_cnt_reg;
    logic [DGW-1:0]  deg_a_reg, deg_b_reg, deg_c_reg;
    logic            found_reg [3];
    logic [ETW-1:0]  idx_reg [3];
    logic [DGW-1:0]  iss_reg;
    logic            s1_v_reg, s2_v_reg, stop_reg;
    logic [EW-1:0]   s2_e_reg;
    logic            app_v_reg [NCALL];
    logic [LAW-1:0]  app_addr_reg [NCALL];
    logic [EW-1:0]   app_edge_reg [NCALL];
    logic [DGW-1:0]  dfin_reg [3];
    logic [2:0]      cnt_reg;
    logic [1:0]      status_reg;
    adj_t            adj_reg;
    logic            adj_valid_reg;

    logic [EW-1:0]   list_mem [MAX_VERTICES*MAX_DEGREE];
    logic [EW-1:0]   list_rd_reg;
    logic [2*VW-1:0] ep_mem [MAX_EDGES];
    logic [2*VW-1:0] ep_rd_reg;
    logic            sec_mem [MAX_EDGES];
    logic            sec_rd_reg;
    logic [DGW-1:0]  deg_mem [MAX_VERTICES];
    logic [DGW-1:0]  deg_rd_reg;

    logic            list_we, ep_we, sec_we, deg_we;
    logic [LAW-1:0]  list_wa, list_ra;
    logic [EW-1:0]   list_wd;
    logic [EW-1:0]   ep_wa, ep_ra, sec_wa, sec_ra;
    logic [2*VW-1:0] ep_wd;
    logic            sec_wd;
    logic [VW-1:0]   deg_wa, deg_ra;
    logic [DGW-1:0]  deg_wd;

    logic [VW-1:0]   vx [3];
    logic [2*VW-1:0] ends_w [3];
    logic            face_full;
    logic [DGW-1:0]  scan_d;
    logic [VW-1:0]   scan_v;
    logic            scan_issue, scan_done;
    logic [VW-1:0]   ep_v0, ep_v1;
    logic            j_ab, j_ac, j_bc, s2_act;
    logic            hit0, hit1, hit2, stop0, stop2;
    logic            load_ovf, load_done;

    logic [ETW-1:0]  a_nx;
    logic [ETW-1:0]  a_ix [3];
    logic [DGW-1:0]  a_dg [3];
    logic            a_av [NCALL];
    logic [DW-1:0]   a_sl [NCALL];
    logic            a_fail, a_ok;

    assign stat.clearing = (state_reg == CLEAR);
    assign adj_valid     = adj_valid_reg;
    assign adj           = adj_reg;

    always_comb
    begin
        vx[0] = job_reg.corners.vertex_a;
        vx[1] = job_reg.corners.vertex_b;
        vx[2] = job_reg.corners.vertex_c;
        ends_w[0] = {vx[1], vx[0]};
        ends_w[1] = {vx[2], vx[1]};
        ends_w[2] = {vx[0], vx[2]};
    end

    assign face_full = (face_total_reg >= FTW'(MAX_FACES));

    // list scan pipeline: list read, endpoint read, compare
    always_comb
    begin
        scan_d = (state_reg == SCAN_A) ? deg_a_reg : deg_b_reg;
        scan_v = (state_reg == SCAN_A) ? vx[0] : vx[1];
        scan_issue = (iss_reg < scan_d) && !stop_reg;
        scan_done  = stop_reg || ((iss_reg >= scan_d) && !s1_v_reg && !s2_v_reg);
        ep_v0 = ep_rd_reg[VW-1:0];
        ep_v1 = ep_rd_reg[2*VW-1:VW];
        j_ab = (ep_v0 == vx[0] && ep_v1 == vx[1]) || (ep_v0 == vx[1] && ep_v1 == vx[0]);
        j_ac = (ep_v0 == vx[0] && ep_v1 == vx[2]) || (ep_v0 == vx[2] && ep_v1 == vx[0]);
        j_bc = (ep_v0 == vx[1] && ep_v1 == vx[2]) || (ep_v0 == vx[2] && ep_v1 == vx[1]);
        s2_act = s2_v_reg && !stop_reg;
        hit0  = (state_reg == SCAN_A) && s2_act && j_ab;
        stop0 = hit0 && found_reg[2];
        hit2  = (state_reg == SCAN_A) && s2_act && j_ac && !stop0;
        stop2 = hit2 && (found_reg[0] || hit0);
        hit1  = (state_reg == SCAN_B) && s2_act && j_bc;
    end

    // edge numbering and list insertion bookkeeping
    always_comb
    begin
        logic pres;
        logic [1:0] v;
        logic [1:0] k;
        a_nx   = edge_total_reg;
        a_fail = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (found_reg[i])
            begin
                a_ix[i] = idx_reg[i];
            end
            else
            begin
                a_ix[i] = a_nx;
                a_nx    = a_nx + ETW'(1);
            end
        end
        a_dg[0] = deg_a_reg;
        a_dg[1] = deg_b_reg;
        a_dg[2] = deg_c_reg;
        for (int j = 0; j < NCALL; j++)
        begin
            v = CALL_V[j];
            k = CALL_K[j];
            pres = found_reg[k];
            a_av[j] = 1'b0;
            a_sl[j] = '0;
            for (int jj = 0; jj < j; jj++)
            begin
                if (a_av[jj] && vsame(CALL_V[jj], v, job_reg.eq_ab, job_reg.eq_bc,
                                      job_reg.eq_ca) && a_ix[CALL_K[jj]] == a_ix[k])
                begin
                    pres = 1'b1;
                end
            end
            if (!pres && !a_fail)
            begin
                if (a_dg[v] >= DGW'(MAX_DEGREE))
                begin
                    a_fail = 1'b1;
                end
                else
                begin
                    a_av[j] = 1'b1;
                    a_sl[j] = a_dg[v][DW-1:0];
                    for (int u = 0; u < 3; u++)
                    begin
                        if (vsame(2'(u), v, job_reg.eq_ab, job_reg.eq_bc, job_reg.eq_ca))
                        begin
                            a_dg[u] = a_dg[u] + DGW'(1);
                        end
                    end
                end
            end
        end
        a_ok = (a_nx <= ETW'(MAX_EDGES)) && !a_fail;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CLEAR:
            begin
                if (&clr_cnt_reg)
                begin
                    state_next = IDLE;
                end
            end
            IDLE:
            begin
                if (q_valid && !adj_valid_reg && !face_full)
                begin
                    state_next = DEG_A;
                end
            end
            DEG_A:   state_next = DEG_B;
            DEG_B:   state_next = DEG_C;
            DEG_C:   state_next = DEG_W;
            DEG_W:   state_next = SCAN_A;
            SCAN_A:
            begin
                if (scan_done)
                begin
                    state_next = SCAN_B;
                end
            end
            SCAN_B:
            begin
                if (scan_done)
                begin
                    state_next = ALLOC;
                end
            end
            ALLOC:   state_next = a_ok ? APPEND : IDLE;
            APPEND:
            begin
                if (cnt_reg == 3'd5)
                begin
                    state_next = EDGE_RD;
                end
            end
            EDGE_RD: state_next = EDGE_WR;
            EDGE_WR: state_next = (cnt_reg == 3'd2) ? DONE : EDGE_RD;
            DONE:    state_next = IDLE;
            default: state_next = IDLE;
        endcase
    end

    always_comb
    begin
        q_pop   = 1'b0;
        list_we = 1'b0;
        list_wa = '0;
        list_wd = '0;
        list_ra = '0;
        ep_we   = 1'b0;
        ep_wa   = '0;
        ep_wd   = '0;
        ep_ra   = '0;
        sec_we  = 1'b0;
        sec_wa  = '0;
        sec_wd  = 1'b0;
        sec_ra  = '0;
        deg_we  = 1'b0;
        deg_wa  = '0;
        deg_wd  = '0;
        deg_ra  = '0;
        unique case (state_reg)
            CLEAR:
            begin
                deg_we = 1'b1;
                deg_wa = clr_cnt_reg;
            end
            IDLE:
            begin
                q_pop = q_valid && !adj_valid_reg;
            end
            DEG_A:   deg_ra = vx[0];
            DEG_B:   deg_ra = vx[1];
            DEG_C:   deg_ra = vx[2];
            SCAN_A, SCAN_B:
            begin
                list_ra = {scan_v, iss_reg[DW-1:0]};
                ep_ra   = list_rd_reg;
            end
            APPEND:
            begin
                list_we = app_v_reg[cnt_reg];
                list_wa = app_addr_reg[cnt_reg];
                list_wd = app_edge_reg[cnt_reg];
                if (cnt_reg < 3'd3)
                begin
                    deg_we = 1'b1;
                    deg_wa = vx[cnt_reg[1:0]];
                    deg_wd = dfin_reg[cnt_reg[1:0]];
                end
            end
            EDGE_RD:
            begin
                sec_ra = idx_reg[cnt_reg[1:0]][EW-1:0];
            end
            EDGE_WR:
            begin
                sec_wa = idx_reg[cnt_reg[1:0]][EW-1:0];
                ep_wa  = idx_reg[cnt_reg[1:0]][EW-1:0];
                ep_wd  = ends_w[cnt_reg[1:0]];
                if (!found_reg[cnt_reg[1:0]])
                begin
                    ep_we  = 1'b1;
                    sec_we = 1'b1;
                end
                else if (!sec_rd_reg)
                begin
                    sec_we = 1'b1;
                    sec_wd = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign load_ovf  = (q_pop && face_full) || (state_reg == ALLOC && !a_ok);
    assign load_done = (state_reg == DONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= CLEAR;
            clr_cnt_reg    <= '0;
            face_total_reg <= '0;
            edge_total_reg <= '0;
            adj_valid_reg  <= 1'b0;
            iss_reg        <= '0;
            s1_v_reg       <= 1'b0;
            s2_v_reg       <= 1'b0;
            stop_reg       <= 1'b0;
            cnt_reg        <= '0;
            for (int i = 0; i < 3; i++)
            begin
                found_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + VW'(1);
            end
            if (load_ovf || load_done)
            begin
                adj_valid_reg <= 1'b1;
            end
            else if (!adj_stall)
            begin
                adj_valid_reg <= 1'b0;
            end
            if (q_pop)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    found_reg[i] <= 1'b0;
                end
            end
            if (hit0)
            begin
                found_reg[0] <= 1'b1;
            end
            if (hit1)
            begin
                found_reg[1] <= 1'b1;
            end
            if (hit2)
            begin
                found_reg[2] <= 1'b1;
            end
            if ((state_reg == SCAN_A || state_reg == SCAN_B) && !scan_done)
            begin
                s1_v_reg <= scan_issue;
                s2_v_reg <= s1_v_reg;
                iss_reg  <= iss_reg + {{(DGW-1){1'b0}}, scan_issue};
                stop_reg <= stop_reg || stop0 || stop2 || hit1;
            end
            else
            begin
                s1_v_reg <= 1'b0;
                s2_v_reg <= 1'b0;
                iss_reg  <= '0;
                stop_reg <= 1'b0;
            end
            if (state_reg == APPEND)
            begin
                cnt_reg <= (cnt_reg == 3'd5) ? 3'd0 : cnt_reg + 3'd1;
            end
            else if (state_reg == EDGE_WR)
            begin
                cnt_reg <= cnt_reg + 3'd1;
            end
            else if (state_reg == ALLOC)
            begin
                cnt_reg <= '0;
            end
            if (load_done)
            begin
                face_total_reg <= face_total_reg + FTW'(1);
                edge_total_reg <= next_total_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_job;
        end
        if (state_reg == DEG_A)
        begin
            status_reg <= STATUS_OK;
        end
        if (state_reg == DEG_B)
        begin
            deg_a_reg <= deg_rd_reg;
        end
        if (state_reg == DEG_C)
        begin
            deg_b_reg <= deg_rd_reg;
        end
        if (state_reg == DEG_W)
        begin
            deg_c_reg <= deg_rd_reg;
        end
        s2_e_reg <= list_rd_reg;
        if (hit0)
        begin
            idx_reg[0] <= {1'b0, s2_e_reg};
        end
        if (hit1)
        begin
            idx_reg[1] <= {1'b0, s2_e_reg};
        end
        if (hit2)
        begin
            idx_reg[2] <= {1'b0, s2_e_reg};
        end
        if (state_reg == ALLOC)
        begin
            next_total_reg <= a_nx;
            for (int i = 0; i < 3; i++)
            begin
                idx_reg[i]  <= a_ix[i];
                dfin_reg[i] <= a_dg[i];
            end
            for (int j = 0; j < NCALL; j++)
            begin
                app_v_reg[j]    <= a_av[j];
                app_addr_reg[j] <= {vx[CALL_V[j]], a_sl[j]};
                app_edge_reg[j] <= a_ix[CALL_K[j]][EW-1:0];
            end
        end
        if (state_reg == EDGE_WR && found_reg[cnt_reg[1:0]] && sec_rd_reg)
        begin
            status_reg <= STATUS_NONMAN;
        end
        if (load_ovf)
        begin
            adj_reg.face_index <= face_total_reg[FIW-1:0];
            adj_reg.edge_ab    <= '0;
            adj_reg.edge_bc    <= '0;
            adj_reg.edge_ca    <= '0;
            adj_reg.new_ab     <= 1'b0;
            adj_reg.new_bc     <= 1'b0;
            adj_reg.new_ca     <= 1'b0;
            adj_reg.status     <= STATUS_OVF;
        end
        else if (load_done)
        begin
            adj_reg.face_index <= face_total_reg[FIW-1:0];
            adj_reg.edge_ab    <= idx_reg[0][EW-1:0];
            adj_reg.edge_bc    <= idx_reg[1][EW-1:0];
            adj_reg.edge_ca    <= idx_reg[2][EW-1:0];
            adj_reg.new_ab     <= !found_reg[0];
            adj_reg.new_bc     <= !found_reg[1];
            adj_reg.new_ca     <= !found_reg[2];
            adj_reg.status     <= status_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (list_we)
        begin
            list_mem[list_wa] <= list_wd;
        end
        list_rd_reg <= list_mem[list_ra];
    end

    always_ff @(posedge clk)
    begin
        if (ep_we)
        begin
            ep_mem[ep_wa] <= ep_wd;
        end
        ep_rd_reg <= ep_mem[ep_ra];
    end

    always_ff @(posedge clk)
    begin
        if (sec_we)
        begin
            sec_mem[sec_wa] <= sec_wd;
        end
        sec_rd_reg <= sec_mem[sec_ra];
    end

    always_ff @(posedge clk)
    begin
        if (deg_we)
        begin
            deg_mem[deg_wa] <= deg_wd;
        end
        deg_rd_reg <= deg_mem[deg_ra];
    end

endmodule

// ===== sv/meab_checker.sv =====
`timescale 1ns / 1ps

module meab_checker
    import meab_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  face_valid,
    input logic  face_stall,
    input face_t face,
    input logic  adj_valid,
    input logic  adj_stall,
    input adj_t  adj
);

    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        face_valid && face_stall |=> face_valid && $stable(face))
        else $error("request changed while stalled");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        adj_valid && adj_stall |=> adj_valid && $stable(adj))
        else $error("result changed while stalled");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        adj_valid |-> (adj.status == STATUS_OK || adj.status == STATUS_NONMAN
                       || adj.status == STATUS_OVF))
        else $error("bad status code");

    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        adj_valid && adj.status == STATUS_OVF |->
            adj.edge_ab == '0 && adj.edge_bc == '0 && adj.edge_ca == '0
            && !adj.new_ab && !adj.new_bc && !adj.new_ca)
        else $error("overflow result carries edges");

    a_newseq: assert property (@(posedge clk) disable iff (!rst_n)
        adj_valid && adj.status != STATUS_OVF && adj.new_ab && adj.new_bc |->
            adj.edge_bc == adj.edge_ab + EW'(1))
        else $error("new edges not numbered in order");

endmodule

bind mesh_edge_adjacency_builder meab_checker u_meab_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .face_valid (face_valid),
    .face_stall (face_stall),
    .face       (face),
    .adj_valid  (adj_valid),
    .adj_stall  (adj_stall),
    .adj        (adj)
);

// ===== dv/mesh_edge_adjacency_builder_tb.sv =====
`timescale 1ns / 1ps

module mesh_edge_adjacency_builder_tb;
    import meab_pkg::*;

    logic  clk;
    logic  rst_n;
    logic  face_valid;
    logic  face_stall;
    face_t face;
    logic  adj_valid;
    logic  adj_stall;
    adj_t  adj;

    int    edge_v0 [MAX_EDGES];
    int    edge_v1 [MAX_EDGES];
    bit    edge_shared [MAX_EDGES];
    int    vertex_deg [MAX_VERTICES];
    int    vertex_list [MAX_VERTICES * MAX_DEGREE];
    int    edges_built;
    int    faces_built;

    adj_t  pending_adj [$];
    int    mismatches;
    int    idle_pct;
    int    stall_pct;

    mesh_edge_adjacency_builder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .face_valid (face_valid),
        .face_stall (face_stall),
        .face       (face),
        .adj_valid  (adj_valid),
        .adj_stall  (adj_stall),
        .adj        (adj)
    );

    always #6 clk = ~clk;

    function automatic bit edge_joins(int e, int x, int y);
        return (edge_v0[e] == x && edge_v1[e] == y) || (edge_v0[e] == y && edge_v1[e] == x);
    endfunction

    function automatic int slots_used(int v);
        return (vertex_deg[v] > MAX_DEGREE) ? MAX_DEGREE : vertex_deg[v];
    endfunction

    function automatic bit list_insert(int v, int e);
        int d;
        int i;
        d = slots_used(v);
        for (i = 0; i < d; i++)
        begin
            if (vertex_list[v * MAX_DEGREE + i] == e)
            begin
                return 1'b1;
            end
        end
        if (d >= MAX_DEGREE)
        begin
            return 1'b0;
        end
        vertex_list[v * MAX_DEGREE + d] = e;
        vertex_deg[v] = d + 1;
        return 1'b1;
    endfunction

    function automatic adj_t predict_adjacency(face_t f);
        int   a;
        int   b;
        int   c;
        int   idx [3];
        bit   found [3];
        int   ends0 [3];
        int   ends1 [3];
        int   nxt;
        int   d;
        int   e;
        int   i;
        int   k;
        int   sa;
        int   sb;
        int   sc;
        bit   ok;
        adj_t r;
        a = f.vertex_a;
        b = f.vertex_b;
        c = f.vertex_c;
        r = '0;
        r.face_index = faces_built[12:0];
        r.status = STATUS_OK;
        for (k = 0; k < 3; k++)
        begin
            idx[k] = 0;
            found[k] = 1'b0;
        end
        if (faces_built >= MAX_FACES)
        begin
            r.status = STATUS_OVF;
            return r;
        end
        d = slots_used(a);
        for (i = 0; i < d; i++)
        begin
            e = vertex_list[a * MAX_DEGREE + i];
            if (edge_joins(e, a, b))
            begin
                idx[0] = e;
                found[0] = 1'b1;
                if (found[2])
                begin
                    break;
                end
            end
            if (edge_joins(e, a, c))
            begin
                idx[2] = e;
                found[2] = 1'b1;
                if (found[0])
                begin
                    break;
                end
            end
        end
        d = slots_used(b);
        for (i = 0; i < d; i++)
        begin
            e = vertex_list[b * MAX_DEGREE + i];
            if (edge_joins(e, b, c))
            begin
                idx[1] = e;
                found[1] = 1'b1;
                break;
            end
        end
        nxt = edges_built;
        for (k = 0; k < 3; k++)
        begin
            if (!found[k])
            begin
                idx[k] = nxt;
                nxt++;
            end
        end
        ok = (nxt <= MAX_EDGES);
        sa = vertex_deg[a];
        sb = vertex_deg[b];
        sc = vertex_deg[c];
        if (ok)
        begin
            ok = list_insert(a, idx[2]) && list_insert(a, idx[0])
              && list_insert(b, idx[0]) && list_insert(b, idx[1])
              && list_insert(c, idx[1]) && list_insert(c, idx[2]);
            if (!ok)
            begin
                vertex_deg[c] = sc;
                vertex_deg[b] = sb;
                vertex_deg[a] = sa;
            end
        end
        if (!ok)
        begin
            r.status = STATUS_OVF;
            return r;
        end
        ends0[0] = a; ends1[0] = b;
        ends0[1] = b; ends1[1] = c;
        ends0[2] = c; ends1[2] = a;
        for (k = 0; k < 3; k++)
        begin
            e = idx[k];
            if (!found[k])
            begin
                edge_v0[e] = ends0[k];
                edge_v1[e] = ends1[k];
                edge_shared[e] = 1'b0;
            end
            else if (edge_shared[e])
            begin
                r.status = STATUS_NONMAN;
            end
            else
            begin
                edge_shared[e] = 1'b1;
            end
        end
        edges_built = nxt;
        faces_built++;
        r.edge_ab = idx[0][13:0];
        r.edge_bc = idx[1][13:0];
        r.edge_ca = idx[2][13:0];
        r.new_ab = !found[0];
        r.new_bc = !found[1];
        r.new_ca = !found[2];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    task automatic send_face(int a, int b, int c);
        face_t f;
        f.vertex_a = a[11:0];
        f.vertex_b = b[11:0];
        f.vertex_c = c[11:0];
        while ($urandom_range(0, 99) < idle_pct)
        begin
            face_valid <= 1'b0;
            @(posedge clk);
        end
        face_valid <= 1'b1;
        face <= f;
        @(posedge clk);
        while (face_stall)
        begin
            @(posedge clk);
        end
        pending_adj.insert(pending_adj.size(), predict_adjacency(f));
    endtask

    task automatic go_quiet();
        face_valid <= 1'b0;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        adj_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        adj_t want;
        if (rst_n && adj_valid && !adj_stall)
        begin
            if (pending_adj.size() == 0)
            begin
                report_mismatch("unexpected result face_index", adj.face_index, -1);
            end
            else
            begin
                want = pending_adj.pop_front();
                if (adj.face_index !== want.face_index)
                    report_mismatch("face_index", adj.face_index, want.face_index);
                if (adj.edge_ab !== want.edge_ab)
                    report_mismatch("edge_ab", adj.edge_ab, want.edge_ab);
                if (adj.edge_bc !== want.edge_bc)
                    report_mismatch("edge_bc", adj.edge_bc, want.edge_bc);
                if (adj.edge_ca !== want.edge_ca)
                    report_mismatch("edge_ca", adj.edge_ca, want.edge_ca);
                if (adj.new_ab !== want.new_ab)
                    report_mismatch("new_ab", adj.new_ab, want.new_ab);
                if (adj.new_bc !== want.new_bc)
                    report_mismatch("new_bc", adj.new_bc, want.new_bc);
                if (adj.new_ca !== want.new_ca)
                    report_mismatch("new_ca", adj.new_ca, want.new_ca);
                if (adj.status !== want.status)
                    report_mismatch("status", adj.status, want.status);
            end
        end
    end

    task automatic test_directed();
        int i;
        send_face(0, 1, 2);
        send_face(2, 1, 0);
        send_face(0, 1, 2);
        send_face(5, 5, 5);
        send_face(5, 5, 6);
        send_face(6, 5, 5);
        send_face(4095, 4095, 0);
        send_face(4095, 0, 1);
        send_face(12'hAAA, 12'h555, 4095);
        // fan around one vertex until its list runs out
        for (i = 0; i < 10; i++)
        begin
            send_face(7, 100 + i, 200 + i);
        end
        send_face(100, 7, 200);
        go_quiet();
    endtask

    task automatic test_mesh(int n, int idle, int stall);
        int i;
        int base;
        idle_pct = idle;
        stall_pct = stall;
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < 10)
            begin
                send_face($urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom_range(0, 4095));
            end
            else
            begin
                if (i % 40 == 0)
                begin
                    base = $urandom_range(0, 4095 - 24);
                end
                send_face(base + $urandom_range(0, 23), base + $urandom_range(0, 23),
                          base + $urandom_range(0, 23));
            end
        end
        go_quiet();
    endtask

    task automatic test_drain_pause();
        idle_pct = 0;
        stall_pct = 30;
        send_face(300, 301, 302);
        send_face(302, 301, 303);
        go_quiet();
        while (pending_adj.size() != 0)
        begin
            @(posedge clk);
        end
        send_face(301, 303, 304);
        go_quiet();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n <= 1'b0;
        face_valid <= 1'b0;
        face <= '0;
        mismatches = 0;
        idle_pct = 0;
        stall_pct = 0;
        edges_built = 0;
        faces_built = 0;
        for (int v = 0; v < MAX_VERTICES; v++)
        begin
            vertex_deg[v] = 0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_mesh(400, 0, 0);
        test_mesh(400, 60, 0);
        test_mesh(400, 0, 60);
        test_drain_pause();
        test_mesh(400, 18, 18);
        while (pending_adj.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (80) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    initial
    begin
        #60ms;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
sv/meab_pkg.sv
sv/meab_front.sv
sv/meab_back.sv
sv/mesh_edge_adjacency_builder.sv
sv/meab_checker.sv
dv/mesh_edge_adjacency_builder_tb.sv
